@@ design/bldc_pkg.sv @@
// Shared types, constants and functions of the binary log deframer.
// No dependencies; every other design file except bldc_if imports this package.
`timescale 1ns / 1ps

package bldc_pkg;

   localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
   localparam logic [23:0] SYNC_RESET    = 24'hAA4412;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

   // register indexes of the configuration port
   localparam logic REG_SYNC_PATTERN = 1'b0;
   localparam logic REG_MAX_LEN      = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_CRC_GOOD = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // message classes
   localparam logic [1:0] CLASS_OTHER    = 2'd0;
   localparam logic [1:0] CLASS_POSITION = 2'd1;
   localparam logic [1:0] CLASS_VELOCITY = 2'd2;

   localparam logic [15:0] ID_POSITION_A = 16'd42;
   localparam logic [15:0] ID_POSITION_B = 16'd47;
   localparam logic [15:0] ID_VELOCITY_A = 16'd99;
   localparam logic [15:0] ID_VELOCITY_B = 16'd100;

   // byte positions inside a frame (count after the byte arrives)
   localparam logic [15:0] COUNT_AFTER_SYNC = 16'd3;
   localparam logic [15:0] COUNT_CRC_START  = 16'd4;
   localparam logic [15:0] COUNT_ID_LO      = 16'd5;
   localparam logic [15:0] COUNT_ID_HI      = 16'd6;
   localparam logic [15:0] COUNT_BODY_LO    = 16'd9;
   localparam logic [15:0] COUNT_BODY_HI    = 16'd10;
   localparam logic [16:0] TRAILER_BYTES    = 17'd4;

   typedef struct packed {
      logic       fire;
      logic [7:0] data;
   } step_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [15:0] msg_id;
      logic [1:0]  msg_class;
      logic [15:0] frame_length;
   } result_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] v;
      v = {24'd0, crc[7:0] ^ data};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return {8'd0, crc[31:8]} ^ v;
   endfunction

   function automatic logic [1:0] class_of(input logic [15:0] id);
      if (id == ID_POSITION_A || id == ID_POSITION_B) begin
         return CLASS_POSITION;
      end else if (id == ID_VELOCITY_A || id == ID_VELOCITY_B) begin
         return CLASS_VELOCITY;
      end
      return CLASS_OTHER;
   endfunction

endpackage

@@ design/bldc_if.sv @@
// Valid/ready channel interfaces for the deframer's byte input and result output.
// No dependencies.
`timescale 1ns / 1ps

interface bldc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface bldc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] msg_id;
   logic [1:0]  msg_class;
   logic [15:0] frame_length;

   modport source (output valid, output status, output msg_id, output msg_class,
                   output frame_length, input ready);
   modport sink   (input valid, input status, input msg_id, input msg_class,
                   input frame_length, output ready);
endinterface

@@ design/binary_log_deframer_crc32_unit.sv @@
// Binary log deframer with CRC-32 check. Takes one byte per request and emits a
// result when a frame completes (CRC good or bad) or overflows at max_len bytes.
// Accepts one byte every cycle while results drain. The byte that ends a frame is
// registered in the input register, and its result is then registered in the result
// register, once that is free, and presented on the result channel. A result held by
// rsp_bus.ready keeps the next byte in the input register, so requests pause only
// while a result waits. The rate is set by the byte-wide CRC update and frame
// counters that sit between the input register and the result register.
// Depends on bldc_pkg and the channel interfaces in bldc_if.
`timescale 1ns / 1ps

module binary_log_deframer_crc32_unit (
   input  logic        clock,
   input  logic        reset,
   bldc_req_if.sink    req_bus,
   bldc_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [23:0] csr_wr_data
);
   import bldc_pkg::*;

   logic [23:0] sync_pattern_ff;
   logic [15:0] max_len_ff;
   step_type    step;
   result_type  res;
   logic        out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_pattern_ff <= SYNC_RESET;
         max_len_ff      <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == REG_SYNC_PATTERN) begin
            sync_pattern_ff <= csr_wr_data;
         end else if (csr_index == REG_MAX_LEN) begin
            max_len_ff <= csr_wr_data[15:0];
         end
      end
   end

   bldc_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .in_data  (req_bus.in_byte),
      .out_free (out_free),
      .step     (step)
   );

   bldc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .sync_pattern (sync_pattern_ff),
      .max_len      (max_len_ff),
      .res          (res)
   );

   bldc_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (step.fire),
      .res          (res),
      .free         (out_free),
      .out_valid    (rsp_bus.valid),
      .out_ready    (rsp_bus.ready),
      .status       (rsp_bus.status),
      .msg_id       (rsp_bus.msg_id),
      .msg_class    (rsp_bus.msg_class),
      .frame_length (rsp_bus.frame_length)
   );

endmodule

@@ design/bldc_in_reg.sv @@
// Input register of the deframer: holds one request byte until the core takes it.
// Depends on bldc_pkg.
`timescale 1ns / 1ps

module bldc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_data,
   input  logic               out_free,
   output bldc_pkg::step_type step
);
   import bldc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       advance;

   assign advance  = valid_ff && out_free;
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign step.fire = advance;
   assign step.data = data_ff;

endmodule

@@ design/bldc_frame.sv @@
// Frame tracker: sync window, byte counter, header fields, CRC-32 and trailer check.
// Depends on bldc_pkg.
`timescale 1ns / 1ps

module bldc_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  bldc_pkg::step_type   step,
   input  logic [23:0]          sync_pattern,
   input  logic [15:0]          max_len,
   output bldc_pkg::result_type res
);
   import bldc_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] window_ff, window_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  hdr_len_ff, hdr_len_in;
   logic [15:0] body_len_ff, body_len_in;
   logic [16:0] total_ff, total_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] trail_ff, trail_in;
   logic [7:0]  b;

   assign b = step.data;

   always_comb begin
      window_in   = {window_ff[15:0], b};
      phase_in    = phase_ff;
      count_in    = count_ff;
      hdr_len_in  = hdr_len_ff;
      body_len_in = body_len_ff;
      total_in    = total_ff;
      id_in       = id_ff;
      crc_in      = crc_ff;
      trail_in    = trail_ff;
      res         = '0;

      if (window_in == sync_pattern) begin
         // restart the frame, no result
         phase_in    = PH_HEADER;
         count_in    = COUNT_AFTER_SYNC;
         hdr_len_in  = '0;
         body_len_in = '0;
         total_in    = '0;
         id_in       = '0;
         crc_in      = '0;
         trail_in    = {sync_pattern[7:0], sync_pattern[15:8], sync_pattern[23:16], 8'd0};
      end else if (phase_ff != PH_IDLE) begin
         if (count_ff >= COUNT_CRC_START) begin
            crc_in = crc_byte(crc_ff, trail_ff[7:0]);
         end
         trail_in = {b, trail_ff[31:8]};
         count_in = count_ff + 16'd1;

         if (count_in == COUNT_ID_LO) begin
            id_in = {id_ff[15:8], b};
         end else if (count_in == COUNT_ID_HI) begin
            id_in = {b, id_ff[7:0]};
         end else if (count_in == COUNT_BODY_LO) begin
            body_len_in = {body_len_ff[15:8], b};
         end else if (count_in == COUNT_BODY_HI) begin
            body_len_in = {b, body_len_ff[7:0]};
         end

         if (count_in >= max_len) begin
            phase_in         = PH_IDLE;
            res.valid        = 1'b1;
            res.status       = STATUS_OVERFLOW;
            res.frame_length = count_in;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (hdr_len_ff == 8'd0) begin
                     hdr_len_in = b;
                  end else if (count_in == {8'd0, hdr_len_ff}) begin
                     total_in = {1'b0, body_len_in} + {9'd0, hdr_len_ff} + TRAILER_BYTES;
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if ({1'b0, count_in} == total_ff) begin
                     phase_in         = PH_IDLE;
                     res.valid        = 1'b1;
                     res.status       = (crc_in == trail_in) ? STATUS_CRC_GOOD
                                                             : STATUS_CRC_BAD;
                     res.msg_id       = id_in;
                     res.msg_class    = class_of(id_in);
                     res.frame_length = count_in;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // hold everything unless a byte is taken
      if (!step.fire) begin
         res.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         window_ff   <= '0;
         count_ff    <= '0;
         hdr_len_ff  <= '0;
         body_len_ff <= '0;
         total_ff    <= '0;
         id_ff       <= '0;
         crc_ff      <= '0;
         trail_ff    <= '0;
      end else if (step.fire) begin
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         count_ff    <= count_in;
         hdr_len_ff  <= hdr_len_in;
         body_len_ff <= body_len_in;
         total_ff    <= total_in;
         id_ff       <= id_in;
         crc_ff      <= crc_in;
         trail_ff    <= trail_in;
      end
   end

endmodule

@@ design/bldc_out_reg.sv @@
// Result register of the deframer: holds one result until the sink takes it.
// Depends on bldc_pkg.
`timescale 1ns / 1ps

module bldc_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bldc_pkg::result_type res,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [1:0]           status,
   output logic [15:0]          msg_id,
   output logic [1:0]           msg_class,
   output logic [15:0]          frame_length
);
   import bldc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = res.valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res.valid) begin
         data_ff <= res;
      end
   end

   assign out_valid    = valid_ff;
   assign status       = data_ff.status;
   assign msg_id       = data_ff.msg_id;
   assign msg_class    = data_ff.msg_class;
   assign frame_length = data_ff.frame_length;

endmodule
